FILE: rtl/core/u8u16_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 / UTF-16 code unit decoder.
// Used by the decode, register stage and top level modules; no dependencies.
package u8u16_pkg;

  typedef enum logic [1:0] {
    MODE_UTF8    = 2'd0,
    MODE_UTF16LE = 2'd1,
    MODE_UTF16BE = 2'd2
  } mode_e;

  localparam logic [1:0] MODE_RESET = MODE_UTF8;

  // Upper bounds of the UTF-8 lead byte classes (inclusive)
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] SKIP4_MAX = 8'hF7;
  localparam logic [7:0] SKIP5_MAX = 8'hFB;
  localparam logic [7:0] SKIP6_MAX = 8'hFD;

  // Bytes still owed after each kind of lead
  localparam logic [2:0] PEND_NONE  = 3'd0;
  localparam logic [2:0] PEND_LEAD2 = 3'd1;
  localparam logic [2:0] PEND_LEAD3 = 3'd2;
  localparam logic [2:0] PEND_SKIP4 = 3'd3;
  localparam logic [2:0] PEND_SKIP5 = 3'd4;
  localparam logic [2:0] PEND_SKIP6 = 3'd5;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_end;
  } result_t;

endpackage

FILE: rtl/core/u8u16_in_if.sv
`timescale 1ns / 1ps
// Input byte channel: valid/ready handshake carrying one string byte.
// Standalone; no package dependency.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

FILE: rtl/core/u8u16_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one decoded code unit.
// Standalone; no package dependency.
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_end;

  modport source (output valid, output code_unit, output unit_valid,
                  output string_end, input ready);
  modport sink   (input valid, input code_unit, input unit_valid,
                  input string_end, output ready);
endinterface

FILE: rtl/core/utf8_utf16_to_code_unit_decoder_core.sv
`timescale 1ns / 1ps
// Byte-serial string decoder: takes one byte word per clock, unless a stalled
// result backs it up, and gives 16-bit code units, decoding UTF-8 (one to three
// byte forms, longer forms skipped) or joining UTF-16 byte pairs in either byte
// order, per the mode register. A byte is captured in the input register, then
// passes through the decode logic into the result register, where its result
// word is offered. A byte that completes no unit and is not the string's last
// gives no result. A stalled result holds the input register; the channel keeps
// taking bytes for as long as the result register drains.
// Write the mode only while no bytes are in flight.
module utf8_utf16_to_code_unit_decoder_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,
  u8u16_in_if.sink     in_i,
  u8u16_out_if.source  out_o
);
  import u8u16_pkg::*;

  mode_e      mode_q;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s2_free;
  logic       advance;
  logic       emit;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mode_e'(MODE_RESET);
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // advance whenever the result register can take a word; quiet bytes just drop
  assign advance = s1_valid && s2_free;

  u8u16_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte),
    .last_o    (s1_last)
  );

  u8u16_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .byte_i    (s1_byte),
    .last_i    (s1_last),
    .advance_i (advance),
    .emit_o    (emit),
    .res_o     (res)
  );

  u8u16_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && emit),
    .res_i  (res),
    .free_o (s2_free),
    .out_o  (out_o)
  );

endmodule

FILE: rtl/core/u8u16_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: captures one byte word per handshake.
// Depends on u8u16_in_if.
module u8u16_in_reg (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8u16_in_if.sink     in_i,
  input  logic         advance_i,
  output logic         valid_o,
  output logic [7:0]   byte_o,
  output logic         last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= in_i.byte_in;
      last_q <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

FILE: rtl/core/u8u16_decode.sv
`timescale 1ns / 1ps
// Decode logic and running string state for the code unit decoder.
// Depends on u8u16_pkg.
module u8u16_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  u8u16_pkg::mode_e   mode_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  input  logic               advance_i,
  output logic               emit_o,
  output u8u16_pkg::result_t res_o
);
  import u8u16_pkg::*;

  logic [2:0]  pend_q, pend_d;
  logic        skip_q, skip_d;
  logic [15:6] part_q, part_d;
  logic        stop_q, stop_d;
  logic [7:0]  held_q, held_d;
  logic        hv_q, hv_d;

  logic [15:0] unit;
  logic        uv;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      skip_q <= 1'b0;
      part_q <= '0;
      stop_q <= 1'b0;
      held_q <= '0;
      hv_q   <= 1'b0;
    end else if (advance_i) begin
      pend_q <= pend_d;
      skip_q <= skip_d;
      part_q <= part_d;
      stop_q <= stop_d;
      held_q <= held_d;
      hv_q   <= hv_d;
    end
  end

  always_comb begin
    pend_d      = pend_q;
    skip_d      = skip_q;
    part_d      = part_q;
    stop_d      = stop_q;
    held_d      = held_q;
    hv_d        = hv_q;
    unit        = 16'h0000;
    uv          = 1'b0;
    first_byte  = hv_q ? held_q : byte_i;
    second_byte = hv_q ? byte_i : 8'h00;

    case (mode_i)
      MODE_UTF8: begin
        if (!stop_q) begin
          if (pend_q != PEND_NONE) begin
            // continuation: take the low six bits whatever the byte is
            if (!skip_q) begin
              if (pend_q == PEND_LEAD3) begin
                part_d[11:6] = part_q[11:6] | byte_i[5:0];
              end else begin
                unit = {part_q, byte_i[5:0]};
                uv   = 1'b1;
              end
            end
            pend_d = pend_q - 3'd1;
            if (pend_q == PEND_LEAD2) begin
              skip_d = 1'b0;
            end
          end else if (!byte_i[7]) begin
            unit = {8'h00, byte_i};
            uv   = 1'b1;
          end else if (byte_i inside {[8'h80:LEAD2_MAX]}) begin
            part_d = {5'b00000, byte_i[4:0]};
            pend_d = PEND_LEAD2;
          end else if (byte_i inside {[8'hE0:LEAD3_MAX]}) begin
            part_d = {byte_i[3:0], 6'b000000};
            pend_d = PEND_LEAD3;
          end else if (byte_i inside {[8'hF0:SKIP4_MAX]}) begin
            skip_d = 1'b1;
            pend_d = PEND_SKIP4;
          end else if (byte_i inside {[8'hF8:SKIP5_MAX]}) begin
            skip_d = 1'b1;
            pend_d = PEND_SKIP5;
          end else if (byte_i inside {[8'hFC:SKIP6_MAX]}) begin
            skip_d = 1'b1;
            pend_d = PEND_SKIP6;
          end else begin
            stop_d = 1'b1;
          end
        end
      end
      MODE_UTF16LE, MODE_UTF16BE: begin
        if (!hv_q && !last_i) begin
          held_d = byte_i;
          hv_d   = 1'b1;
        end else begin
          // pair with the held byte, or with zero on an odd last byte
          held_d = 8'h00;
          hv_d   = 1'b0;
          uv     = 1'b1;
          if (mode_i == MODE_UTF16BE) begin
            unit = {first_byte, second_byte};
          end else begin
            unit = {second_byte, first_byte};
          end
        end
      end
      default: begin
      end
    endcase

    if (last_i) begin
      pend_d = PEND_NONE;
      skip_d = 1'b0;
      part_d = '0;
      stop_d = 1'b0;
      held_d = 8'h00;
      hv_d   = 1'b0;
    end
  end

  assign emit_o           = uv || last_i;
  assign res_o.code_unit  = unit;
  assign res_o.unit_valid = uv;
  assign res_o.string_end = last_i;

endmodule

FILE: rtl/core/u8u16_out_reg.sv
`timescale 1ns / 1ps
// Result register stage: holds one result word until the sink takes it.
// Depends on u8u16_pkg and u8u16_out_if.
module u8u16_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u8u16_pkg::result_t res_i,
  output logic               free_o,
  u8u16_out_if.source        out_o
);
  import u8u16_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.code_unit  = res_q.code_unit;
  assign out_o.unit_valid = res_q.unit_valid;
  assign out_o.string_end = res_q.string_end;

endmodule

FILE: rtl/core/u8u16_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the code unit decoder, bound to its top level.
// Depends on utf8_utf16_to_code_unit_decoder_core.
module u8u16_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] code_unit_i,
  input  logic        unit_valid_i,
  input  logic        string_end_i
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_unit_i)
      && $stable(unit_valid_i) && $stable(string_end_i))
    else $error("stalled result changed");

  // every result carries a unit or marks the end of the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> unit_valid_i || string_end_i)
    else $error("empty result word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !unit_valid_i |-> code_unit_i == 16'h0000)
    else $error("code unit not zero without a unit");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output free");

endmodule

bind utf8_utf16_to_code_unit_decoder_core u8u16_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .code_unit_i  (out_o.code_unit),
  .unit_valid_i (out_o.unit_valid),
  .string_end_i (out_o.string_end)
);

FILE: sim/utf8_utf16_to_code_unit_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the byte-serial UTF-8 / UTF-16 code unit decoder.
// Needs u8u16_pkg, the two channel interfaces and the decoder top level.
module utf8_utf16_to_code_unit_decoder_core_tb;
  import u8u16_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam result_t NO_RES = '0;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  b;
    logic        l;
    bit          typed;
    result_t     want;
  } step_row_t;

  // typed rows carry the unit that the byte must give; the rest use the decoder model
  step_row_t dir_rows [25] = '{
    '{MODE_UTF8,    8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
    '{MODE_UTF8,    8'h7F, 1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0}},
    '{MODE_UTF8,    8'hDF, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hFF, 1'b0, 1'b1, '{16'h07FF, 1'b1, 1'b0}},
    '{MODE_UTF8,    8'hEF, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hBF, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hBF, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    '{MODE_UTF8,    8'hF0, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'h41, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'h42, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'h43, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hC3, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hA9, 1'b1, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hE2, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'h82, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{MODE_UTF8,    8'hFE, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'h41, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
    '{MODE_UTF8,    8'hC3, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF16LE, 8'h34, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF8,    8'hA9, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF16LE, 8'h12, 1'b0, 1'b1, '{16'h1234, 1'b1, 1'b0}},
    '{MODE_UTF16LE, 8'hAB, 1'b1, 1'b1, '{16'h00AB, 1'b1, 1'b1}},
    '{MODE_UTF16BE, 8'h12, 1'b0, 1'b0, NO_RES},
    '{MODE_UTF16BE, 8'h34, 1'b0, 1'b1, '{16'h1234, 1'b1, 1'b0}},
    '{MODE_UTF16BE, 8'hFF, 1'b1, 1'b1, '{16'hFF00, 1'b1, 1'b1}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_data_i;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_utf16_to_code_unit_decoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // decoder model state
  mode_e       cur_mode = MODE_UTF8;
  logic [2:0]  owed     = PEND_NONE;
  bit          dropping = 1'b0;
  logic [15:0] gathered = '0;
  bit          halted   = 1'b0;
  logic [7:0]  pair_byte = '0;
  bit          pair_held = 1'b0;

  result_t     units_due [$];
  result_t     due_unit;
  int          mismatches = 0;
  int          cycle_cnt  = 0;
  bit          tx_gaps    = 1'b1;
  bit          rx_gaps    = 1'b1;
  bit          hold_req   = 1'b0;

  function automatic bit decode_step(input logic [7:0] b, input logic l,
                                     output result_t r);
    logic [15:0] u;
    logic [7:0]  hi;
    logic [7:0]  lo;
    bit          got;
    u   = '0;
    got = 1'b0;
    case (cur_mode)
      MODE_UTF8: begin
        if (!halted) begin
          if (owed != PEND_NONE) begin
            if (!dropping) begin
              if (owed == PEND_LEAD3) begin
                gathered = gathered | {4'b0, b[5:0], 6'b0};
              end else begin
                u   = gathered | {10'b0, b[5:0]};
                got = 1'b1;
              end
            end
            owed = owed - 3'd1;
            if (owed == PEND_NONE) dropping = 1'b0;
          end else if (b < 8'h80) begin
            u   = {8'h00, b};
            got = 1'b1;
          end else if (b <= LEAD2_MAX) begin
            gathered = {5'b0, b[4:0], 6'b0};
            owed     = PEND_LEAD2;
          end else if (b <= LEAD3_MAX) begin
            gathered = {b[3:0], 12'b0};
            owed     = PEND_LEAD3;
          end else if (b <= SKIP4_MAX) begin
            dropping = 1'b1;
            owed     = PEND_SKIP4;
          end else if (b <= SKIP5_MAX) begin
            dropping = 1'b1;
            owed     = PEND_SKIP5;
          end else if (b <= SKIP6_MAX) begin
            dropping = 1'b1;
            owed     = PEND_SKIP6;
          end else begin
            halted = 1'b1;
          end
        end
      end
      MODE_UTF16LE, MODE_UTF16BE: begin
        if (!pair_held && !l) begin
          pair_byte = b;
          pair_held = 1'b1;
        end else begin
          // an unpaired last byte pairs with zero
          hi = pair_held ? pair_byte : b;
          lo = pair_held ? b : 8'h00;
          u  = (cur_mode == MODE_UTF16BE) ? {hi, lo} : {lo, hi};
          got       = 1'b1;
          pair_held = 1'b0;
          pair_byte = '0;
        end
      end
      default: ;
    endcase
    if (l) begin
      owed      = PEND_NONE;
      dropping  = 1'b0;
      gathered  = '0;
      halted    = 1'b0;
      pair_byte = '0;
      pair_held = 1'b0;
    end
    r.code_unit  = got ? u : 16'h0000;
    r.unit_valid = got;
    r.string_end = l;
    return got || l;
  endfunction

  function automatic logic [7:0] tail_byte();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range('h80, 'hBF));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                           input result_t want);
    result_t r;
    bit      has;
    @(negedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.byte_in   <= b;
    in_ch.last_byte <= l;
    do @(posedge clk_i); while (!in_ch.ready);
    has = decode_step(b, l, r);
    if (typed) units_due = {units_due, want};
    else if (has) units_due = {units_due, r};
  endtask

  task automatic pause(input int n);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Drain all words and let the pipeline settle before touching the mode.
  task automatic set_mode(input mode_e m);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("utf8_utf16_to_code_unit_decoder_core_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (units_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: unit %h valid %b end %b",
                   out_ch.code_unit, out_ch.unit_valid, out_ch.string_end);
      end else begin
        due_unit = units_due.pop_front();
        if (out_ch.code_unit !== due_unit.code_unit ||
            out_ch.unit_valid !== due_unit.unit_valid ||
            out_ch.string_end !== due_unit.string_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected unit %h valid %b end %b, got unit %h valid %b end %b",
                     due_unit.code_unit, due_unit.unit_valid, due_unit.string_end,
                     out_ch.code_unit, out_ch.unit_valid, out_ch.string_end);
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back up the block.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] str_q [$];
    logic [7:0] lead;
    mode_e      pm;
    int         len;
    int         kind;
    int         sent;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= MODE_RESET;
    in_ch.valid     <= 1'b0;
    in_ch.byte_in   <= '0;
    in_ch.last_byte <= 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_mode(MODE_UTF8);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) set_mode(dir_rows[i].mode);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 19));
      push_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      pm = (p < 3) ? mode_e'(p) : mode_e'($urandom_range(0, 2));
      set_mode(pm);
      tx_gaps = (p != 1 && p != 4 && p < PHASES - 2);
      rx_gaps = tx_gaps;
      if (p == 1) hold_req = 1'b1;
      sent = 0;
      // a phase may end mid-string, so the state carries into the next mode
      while (sent < PHASE_ITEMS) begin
        str_q.delete();
        len = $urandom_range(1, 24);
        while (str_q.size() < len) begin
          if (pm != MODE_UTF8) begin
            str_q = {str_q, 8'($urandom)};
          end else begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
              str_q = {str_q, 8'($urandom_range(0, 'h7F))};
            end else if (kind < 55) begin
              lead = ($urandom_range(0, 4) == 0) ? 8'($urandom_range('h80, 'hBF))
                                                 : 8'($urandom_range('hC0, 'hDF));
              str_q = {str_q, lead};
              str_q = {str_q, tail_byte()};
            end else if (kind < 75) begin
              str_q = {str_q, 8'($urandom_range('hE0, 'hEF))};
              str_q = {str_q, tail_byte()};
              str_q = {str_q, tail_byte()};
            end else if (kind < 87) begin
              lead = 8'($urandom_range('hF0, 'hFD));
              str_q = {str_q, lead};
              repeat ((lead <= SKIP4_MAX) ? 3 : (lead <= SKIP5_MAX) ? 4 : 5)
                str_q = {str_q, tail_byte()};
            end else if (kind < 98) begin
              str_q = {str_q, 8'($urandom)};
            end else begin
              str_q = {str_q, 8'($urandom_range('hFE, 'hFF))};
            end
          end
        end
        // cutting at len drops the tail of a sequence now and then
        for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
          if (tx_gaps && $urandom_range(0, 5) == 0) pause($urandom_range(1, 19));
          push_byte(str_q[i], i == len - 1, 1'b0, NO_RES);
          sent++;
        end
      end
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && units_due.size() == 0) begin
      $display("utf8_utf16_to_code_unit_decoder_core_tb passed");
    end else begin
      $display("utf8_utf16_to_code_unit_decoder_core_tb failed");
    end
    $finish;
  end

endmodule
